// ===== hw/rtl/ufs_pkg.sv =====
// Package for the URL field splitter: phase and tag codes, delimiter bytes
// and the letter test. Depends on nothing; the splitter, its checker and the testbench use it.
package ufs_pkg;

    // Parse phases of the URL walker.
    typedef enum logic [3:0] {
        PH_SCHEME = 4'd0,
        PH_SLASH1 = 4'd1,
        PH_SLASH2 = 4'd2,
        PH_HOST   = 4'd3,
        PH_PORT   = 4'd4,
        PH_PATH   = 4'd5,
        PH_QUERY  = 4'd6,
        PH_FRAG   = 4'd7,
        PH_ERROR  = 4'd8
    } t_phase;

    // Field tags attached to each byte.
    typedef enum logic [2:0] {
        TAG_DELIM  = 3'd0,
        TAG_SCHEME = 3'd1,
        TAG_HOST   = 3'd2,
        TAG_PORT   = 3'd3,
        TAG_PATH   = 3'd4,
        TAG_QUERY  = 3'd5,
        TAG_FRAG   = 3'd6
    } t_tag;

    // Delimiter bytes.
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;

    // True for ASCII letters A-Z and a-z.
    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

// ===== hw/rtl/ufs_if.sv =====
// Channel interfaces of the URL field splitter: byte input and tagged output.
// Depends on nothing but the fixed field widths of the block.
interface ufs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface ufs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] field_tag;
    logic       bad_url;
    logic       url_done;

    modport source (output valid, output out_byte, output field_tag,
                    output bad_url, output url_done, input ready);
    modport sink   (input valid, input out_byte, input field_tag,
                    input bad_url, input url_done, output ready);
endinterface

// ===== hw/rtl/url_field_splitter.sv =====
// URL field splitter: an input register, the phase machine, and a result register.
// Depends on ufs_pkg and the channel interfaces in ufs_if.sv.
// Path: a byte taken in is held in the input register, then moved into the result register,
// which shows it on the output.
// Throughput: one byte per cycle while the output is not stalled; the phase register is updated
// as each byte leaves the input register, so consecutive bytes flow without gaps.
// Reset: synchronous, active low; both register stages empty and the phase returns
// to the scheme phase.
module url_field_splitter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ufs_in_if.sink            i_in,
    ufs_out_if.source         o_out
);

    // Input register stage.
    logic        r_in_valid;
    logic [7:0]  r_ch;
    logic        r_end;

    // Parse state.
    ufs_pkg::t_phase r_phase;

    // Result register stage.
    logic            r_out_valid;
    logic [7:0]      r_byte;
    ufs_pkg::t_tag   r_tag;
    logic            r_bad;
    logic            r_done;

    // Combinational results for the byte in the input register.
    ufs_pkg::t_phase n_phase;
    ufs_pkg::t_tag   n_tag;
    logic            n_bad;

    logic out_free;
    logic advance;

    // The result register can take a new byte when it is empty or being drained.
    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    // Phase machine: next phase, tag and error flag for the held byte.
    always_comb begin
        n_phase = r_phase;
        n_tag   = ufs_pkg::TAG_DELIM;
        n_bad   = 1'b0;
        unique case (r_phase)
            ufs_pkg::PH_SCHEME: begin
                if (r_ch == ufs_pkg::CH_COLON) begin
                    n_phase = ufs_pkg::PH_SLASH1;
                end else if (ufs_pkg::is_letter(r_ch)) begin
                    n_tag = ufs_pkg::TAG_SCHEME;
                end else begin
                    n_phase = ufs_pkg::PH_ERROR;
                end
            end
            ufs_pkg::PH_SLASH1: begin
                n_phase = (r_ch == ufs_pkg::CH_SLASH) ? ufs_pkg::PH_SLASH2 : ufs_pkg::PH_ERROR;
            end
            ufs_pkg::PH_SLASH2: begin
                n_phase = (r_ch == ufs_pkg::CH_SLASH) ? ufs_pkg::PH_HOST : ufs_pkg::PH_ERROR;
            end
            ufs_pkg::PH_HOST: begin
                if (r_ch == ufs_pkg::CH_COLON) begin
                    n_phase = ufs_pkg::PH_PORT;
                end else if (r_ch == ufs_pkg::CH_SLASH) begin
                    n_phase = ufs_pkg::PH_PATH;
                end else begin
                    n_tag = ufs_pkg::TAG_HOST;
                end
            end
            ufs_pkg::PH_PORT: begin
                if (r_ch == ufs_pkg::CH_SLASH) begin
                    n_phase = ufs_pkg::PH_PATH;
                end else begin
                    n_tag = ufs_pkg::TAG_PORT;
                end
            end
            ufs_pkg::PH_PATH: begin
                if (r_ch == ufs_pkg::CH_QMARK) begin
                    n_phase = ufs_pkg::PH_QUERY;
                end else if (r_ch == ufs_pkg::CH_HASH) begin
                    n_phase = ufs_pkg::PH_FRAG;
                end else begin
                    n_tag = ufs_pkg::TAG_PATH;
                end
            end
            ufs_pkg::PH_QUERY: begin
                if (r_ch == ufs_pkg::CH_HASH) begin
                    n_phase = ufs_pkg::PH_FRAG;
                end else begin
                    n_tag = ufs_pkg::TAG_QUERY;
                end
            end
            ufs_pkg::PH_FRAG: begin
                n_tag = ufs_pkg::TAG_FRAG;
            end
            default: begin
                n_phase = ufs_pkg::PH_ERROR;
            end
        endcase

        // An error masks the tag; an end before the path is also malformed.
        if (n_phase == ufs_pkg::PH_ERROR) begin
            n_bad = 1'b1;
            n_tag = ufs_pkg::TAG_DELIM;
        end else if (r_end && (n_phase <= ufs_pkg::PH_PORT)) begin
            n_bad = 1'b1;
        end
    end

    // Input register: take a transfer whenever the stage is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_ch  <= i_in.ch;
            r_end <= i_in.is_end;
        end
    end

    // Phase register: moves on as each byte leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ufs_pkg::PH_SCHEME;
        end else if (advance) begin
            r_phase <= r_end ? ufs_pkg::PH_SCHEME : n_phase;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (advance) begin
            r_byte <= r_ch;
            r_tag  <= n_tag;
            r_bad  <= n_bad;
            r_done <= r_end;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_byte;
    assign o_out.field_tag = r_tag;
    assign o_out.bad_url   = r_bad;
    assign o_out.url_done  = r_done;

endmodule

// ===== hw/rtl/ufs_checker.sv =====
// Port-level checks for the URL field splitter, bound into url_field_splitter.
// Depends on ufs_pkg and on the url_field_splitter ports.
module ufs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic [2:0] i_field_tag,
    input  logic       i_bad_url
);

    // A result is never shown in the cycle right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)
            && $stable(i_field_tag) && $stable(i_bad_url)))
        else $error("stalled result changed");

    // Only letters are tagged as scheme.
    a_scheme_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_field_tag == ufs_pkg::TAG_SCHEME))
            |-> ufs_pkg::is_letter(i_out_byte))
        else $error("scheme tag on a non-letter byte");

    // In a well-formed URL a delimiter tag only marks a separator byte.
    a_delim_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_bad_url && (i_field_tag == ufs_pkg::TAG_DELIM))
            |-> ((i_out_byte == ufs_pkg::CH_COLON) || (i_out_byte == ufs_pkg::CH_SLASH)
                || (i_out_byte == ufs_pkg::CH_QMARK) || (i_out_byte == ufs_pkg::CH_HASH)))
        else $error("delimiter tag on a non-separator byte");

    // Tags stay within the defined codes.
    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_field_tag != 3'd7))
        else $error("undefined field tag");

endmodule

bind url_field_splitter ufs_checker u_ufs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_field_tag (o_out.field_tag),
    .i_bad_url   (o_out.bad_url)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for url_field_splitter: a directed table, then random URLs.
// Depends on ufs_pkg, the channel interfaces in ufs_if.sv and the url_field_splitter RTL.
module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FIRST  = 600;
    localparam int QUIET_LAST   = 900;

    // One input byte, with an optional hand-written expectation.
    typedef struct packed {
        logic [7:0]    ch;
        logic          last;
        logic          typed;
        ufs_pkg::t_tag tag;
        logic          bad;
    } t_url_row;

    // One tagged byte as the block should produce it.
    typedef struct packed {
        logic [7:0]    data;
        ufs_pkg::t_tag tag;
        logic          bad;
        logic          done;
    } t_tagged_byte;

    logic clk;
    logic rst_n;

    ufs_in_if  byte_ch ();
    ufs_out_if tag_ch ();

    url_field_splitter uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_ch),
        .o_out   (tag_ch)
    );

    t_url_row        url_stim [$];
    t_tagged_byte    tagged_q [$];
    logic [7:0]      url_buf  [$];
    ufs_pkg::t_phase url_phase = ufs_pkg::PH_SCHEME;
    int              mismatch_count = 0;
    int              bytes_sent = 0;
    int              results_seen = 0;
    int              cycle_count = 0;

    // Directed rows: empty fields, second colon in the port, errors and early ends.
    t_url_row dir_rows [0:24] = '{
        // Scheme, host, port; the second colon stays in the port; end in the port.
        '{"Z",               1'b0, 1'b1, ufs_pkg::TAG_SCHEME, 1'b0},
        '{ufs_pkg::CH_COLON, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_SLASH, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_SLASH, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{"h",               1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_COLON, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{"9",               1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_COLON, 1'b1, 1'b1, ufs_pkg::TAG_PORT,   1'b1},
        // Empty scheme and host, a path, a query, and a fragment ending on 0xFF.
        '{ufs_pkg::CH_COLON, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_SLASH, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_SLASH, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_SLASH, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{"p",               1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_QMARK, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{"q",               1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_HASH,  1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{8'hFF,             1'b1, 1'b1, ufs_pkg::TAG_FRAG,   1'b0},
        // A NUL byte in the scheme is an error that sticks to the end.
        '{8'h00,             1'b0, 1'b1, ufs_pkg::TAG_DELIM,  1'b1},
        '{ufs_pkg::CH_COLON, 1'b1, 1'b1, ufs_pkg::TAG_DELIM,  1'b1},
        // Missing first slash.
        '{ufs_pkg::CH_COLON, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{"x",               1'b1, 1'b1, ufs_pkg::TAG_DELIM,  1'b1},
        // Missing second slash.
        '{ufs_pkg::CH_COLON, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{ufs_pkg::CH_SLASH, 1'b0, 1'b0, ufs_pkg::TAG_DELIM,  1'b0},
        '{"a",               1'b1, 1'b1, ufs_pkg::TAG_DELIM,  1'b1},
        // End inside the scheme.
        '{"q",               1'b1, 1'b1, ufs_pkg::TAG_SCHEME, 1'b1}
    };

    function automatic logic ascii_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // Tags one byte and advances the expected parse phase.
    function automatic void tag_url_byte(input logic [7:0] c, input logic last_byte,
                                         output ufs_pkg::t_tag tag, output logic bad);
        ufs_pkg::t_phase nx;
        nx  = url_phase;
        tag = ufs_pkg::TAG_DELIM;
        bad = 1'b0;
        case (url_phase)
            ufs_pkg::PH_SCHEME: begin
                if (c == ufs_pkg::CH_COLON) nx = ufs_pkg::PH_SLASH1;
                else if (ascii_letter(c)) tag = ufs_pkg::TAG_SCHEME;
                else nx = ufs_pkg::PH_ERROR;
            end
            ufs_pkg::PH_SLASH1:
                nx = (c == ufs_pkg::CH_SLASH) ? ufs_pkg::PH_SLASH2 : ufs_pkg::PH_ERROR;
            ufs_pkg::PH_SLASH2:
                nx = (c == ufs_pkg::CH_SLASH) ? ufs_pkg::PH_HOST : ufs_pkg::PH_ERROR;
            ufs_pkg::PH_HOST: begin
                if (c == ufs_pkg::CH_COLON) nx = ufs_pkg::PH_PORT;
                else if (c == ufs_pkg::CH_SLASH) nx = ufs_pkg::PH_PATH;
                else tag = ufs_pkg::TAG_HOST;
            end
            ufs_pkg::PH_PORT: begin
                if (c == ufs_pkg::CH_SLASH) nx = ufs_pkg::PH_PATH;
                else tag = ufs_pkg::TAG_PORT;
            end
            ufs_pkg::PH_PATH: begin
                if (c == ufs_pkg::CH_QMARK) nx = ufs_pkg::PH_QUERY;
                else if (c == ufs_pkg::CH_HASH) nx = ufs_pkg::PH_FRAG;
                else tag = ufs_pkg::TAG_PATH;
            end
            ufs_pkg::PH_QUERY: begin
                if (c == ufs_pkg::CH_HASH) nx = ufs_pkg::PH_FRAG;
                else tag = ufs_pkg::TAG_QUERY;
            end
            ufs_pkg::PH_FRAG: tag = ufs_pkg::TAG_FRAG;
            default: nx = ufs_pkg::PH_ERROR;
        endcase
        // Errors blank the tag; an end before the path is malformed too.
        if (nx == ufs_pkg::PH_ERROR) begin
            bad = 1'b1;
            tag = ufs_pkg::TAG_DELIM;
        end else if (last_byte && nx <= ufs_pkg::PH_PORT) begin
            bad = 1'b1;
        end
        url_phase = last_byte ? ufs_pkg::PH_SCHEME : nx;
    endfunction

    function automatic void queue_byte(input logic [7:0] c, input logic last_byte);
        t_url_row row;
        row       = '0;
        row.ch    = c;
        row.last  = last_byte;
        url_stim.push_back(row);
    endfunction

    // Random byte that avoids two field terminators; half the time printable only.
    function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do begin
            c = $urandom_range(1) ? 8'($urandom_range(126, 33)) : 8'($urandom_range(255));
        end while (c == a || c == b);
        return c;
    endfunction

    // Builds one URL with random content, optionally with one byte spoiled.
    function automatic void gen_url(input logic spoil);
        int n;
        url_buf.delete();
        n = $urandom_range(4);
        repeat (n) url_buf.push_back($urandom_range(1) ? 8'($urandom_range(8'h5A, 8'h41))
                                                       : 8'($urandom_range(8'h7A, 8'h61)));
        url_buf.push_back(ufs_pkg::CH_COLON);
        url_buf.push_back(ufs_pkg::CH_SLASH);
        url_buf.push_back(ufs_pkg::CH_SLASH);
        n = $urandom_range(5);
        repeat (n) url_buf.push_back(byte_except(ufs_pkg::CH_COLON, ufs_pkg::CH_SLASH));
        if ($urandom_range(1)) begin
            url_buf.push_back(ufs_pkg::CH_COLON);
            n = $urandom_range(3);
            repeat (n) url_buf.push_back(byte_except(ufs_pkg::CH_SLASH, ufs_pkg::CH_SLASH));
        end
        // Most URLs go on into the path; the rest end early in host or port.
        if ($urandom_range(9) != 0) begin
            url_buf.push_back(ufs_pkg::CH_SLASH);
            n = $urandom_range(6);
            repeat (n) url_buf.push_back(byte_except(ufs_pkg::CH_QMARK, ufs_pkg::CH_HASH));
            if ($urandom_range(1)) begin
                url_buf.push_back(ufs_pkg::CH_QMARK);
                n = $urandom_range(4);
                repeat (n) url_buf.push_back(byte_except(ufs_pkg::CH_HASH, ufs_pkg::CH_HASH));
            end
            if ($urandom_range(1)) begin
                url_buf.push_back(ufs_pkg::CH_HASH);
                n = $urandom_range(4);
                repeat (n) url_buf.push_back(8'($urandom_range(255)));
            end
        end
        if (spoil) url_buf[$urandom_range(url_buf.size() - 1)] = 8'($urandom_range(255));
        foreach (url_buf[i]) queue_byte(url_buf[i], i == url_buf.size() - 1);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Cycle counter that ends a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Input driver: predicts each transfer, then offers the next byte or idles.
    always @(posedge clk) begin
        t_tagged_byte  want;
        ufs_pkg::t_tag want_tag;
        logic          want_bad;
        if (!rst_n) begin
            byte_ch.valid <= 1'b0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                tag_url_byte(byte_ch.ch, byte_ch.is_end, want_tag, want_bad);
                if (url_stim[0].typed) begin
                    want_tag = url_stim[0].tag;
                    want_bad = url_stim[0].bad;
                end
                want.data = byte_ch.ch;
                want.tag  = want_tag;
                want.bad  = want_bad;
                want.done = byte_ch.is_end;
                tagged_q.push_back(want);
                void'(url_stim.pop_front());
                bytes_sent <= bytes_sent + 1;
            end
            if (!byte_ch.valid || byte_ch.ready) begin
                if (url_stim.size() != 0 &&
                    ((bytes_sent >= QUIET_FIRST && bytes_sent < QUIET_LAST) ||
                     $urandom_range(99) >= 10)) begin
                    byte_ch.valid  <= 1'b1;
                    byte_ch.ch     <= url_stim[0].ch;
                    byte_ch.is_end <= url_stim[0].last;
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output ready with random stalls, and a stretch without any.
    always @(posedge clk) begin
        if (!rst_n) begin
            tag_ch.ready <= 1'b0;
        end else begin
            tag_ch.ready <= (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) ||
                            ($urandom_range(99) >= 10);
        end
    end

    // Result checker: each transfer out is compared with the oldest expected byte.
    always @(posedge clk) begin
        t_tagged_byte want;
        if (rst_n && tag_ch.valid && tag_ch.ready) begin
            results_seen <= results_seen + 1;
            if (tagged_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         tag_ch.out_byte);
            end else begin
                want = tagged_q.pop_front();
                check_field("out_byte", want.data, tag_ch.out_byte);
                check_field("field_tag", 8'(want.tag), 8'(tag_ch.field_tag));
                check_field("bad_url", 8'(want.bad), 8'(tag_ch.bad_url));
                check_field("url_done", 8'(want.done), 8'(tag_ch.url_done));
            end
        end
    end

    // Stimulus build, reset, and end of run.
    initial begin
        int pick;
        int n;
        rst_n          = 1'b0;
        byte_ch.valid  = 1'b0;
        byte_ch.ch     = 8'h00;
        byte_ch.is_end = 1'b0;
        tag_ch.ready   = 1'b0;

        foreach (dir_rows[i]) url_stim.push_back(dir_rows[i]);

        // Mostly well-formed URLs, some spoiled, some raw noise.
        while (url_stim.size() < $size(dir_rows) + RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                gen_url(1'b0);
            end else if (pick < 92) begin
                gen_url(1'b1);
            end else begin
                n = $urandom_range(8, 1);
                for (int k = 0; k < n; k++)
                    queue_byte(8'($urandom_range(255)), k == n - 1 || $urandom_range(9) == 0);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (url_stim.size() != 0 || byte_ch.valid || tagged_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && tagged_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ufs_pkg.sv
hw/rtl/ufs_if.sv
hw/rtl/url_field_splitter.sv
hw/rtl/ufs_checker.sv
sim/tb_top.sv
